// ----- src/fully_associative_lru_cache_classifier_macros.svh -----
// Assertion macros used by the checker of the cache classifier.
// Each macro expands to one labeled concurrent assertion that is sampled on the
// rising edge and is switched off while reset is high.
`ifndef FULLY_ASSOCIATIVE_LRU_CACHE_CLASSIFIER_MACROS_SVH
`define FULLY_ASSOCIATIVE_LRU_CACHE_CLASSIFIER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FALRU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FALRU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/falru_pkg.sv -----
`timescale 1ns / 1ps

package falru_pkg;

  // Fixed field widths of the item channels.
  localparam int ADDR_W = 16;
  localparam int CNT_W  = 32;
  localparam int KIND_W = 2;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int CAP_W   = 6;
  localparam logic [PADDR_W-1:0] CAPACITY_ADDR  = 3'd0;
  localparam logic [CAP_W-1:0]   CAPACITY_RESET = 6'd18;

  typedef enum logic [KIND_W-1:0] {
    KIND_HIT        = 2'd0,
    KIND_COMPULSORY = 2'd1,
    KIND_CAPACITY   = 2'd2
  } miss_kind_t;

  // Requests from the lookup control to the seen-address map.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } seen_req_t;

endpackage

// ----- src/falru_access_if.sv -----
`timescale 1ns / 1ps

interface falru_access_if;
  logic                        valid;
  logic                        ready;
  logic [falru_pkg::ADDR_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);
endinterface

// ----- src/falru_result_if.sv -----
`timescale 1ns / 1ps

interface falru_result_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [falru_pkg::KIND_W-1:0] miss_kind;
  logic [falru_pkg::CNT_W-1:0]  access_count;
  logic [falru_pkg::CNT_W-1:0]  compulsory_count;
  logic [falru_pkg::CNT_W-1:0]  capacity_count;

  modport source (output valid, output hit, output miss_kind, output access_count,
                  output compulsory_count, output capacity_count, input ready);
  modport sink (input valid, input hit, input miss_kind, input access_count,
                input compulsory_count, input capacity_count, output ready);
endinterface

// ----- src/falru_seen_map.sv -----
`timescale 1ns / 1ps

module falru_seen_map #(
  parameter int ADDR_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  falru_pkg::seen_req_t  req,
  input  logic [ADDR_BITS-1:0]  rd_addr,
  input  logic [ADDR_BITS-1:0]  wr_addr,
  output logic                  rd_data,
  output logic                  ready
);

  logic                 mem [2**ADDR_BITS];
  logic [ADDR_BITS-1:0] clr_addr;
  logic                 clearing;

  // After reset every bit is zeroed, one address per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 1'b0;
    end else if (req.wr_en) begin
      mem[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign ready = !clearing;

endmodule

// ----- src/fully_associative_lru_cache_classifier.sv -----
// Flow: an accepted item enters the lookup state and its result is registered when
// the lookup commits, which waits while the previous result still waits at the output.
// No new item is taken until the lookup commits; the seen-address bit is read in the cycle
// of acceptance and written back when the lookup commits.
// Reset: synchronous; afterwards the seen-address memory is cleared one address at a
// time, with no item taken meanwhile.
`timescale 1ns / 1ps

module fully_associative_lru_cache_classifier #(
  parameter int MAX_ENTRIES = 32,
  parameter int ADDR_BITS   = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  falru_access_if.sink                     access,
  falru_result_if.source                   result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [falru_pkg::PADDR_W-1:0]    paddr,
  input  logic [falru_pkg::PDATA_W-1:0]    pwdata,
  output logic [falru_pkg::PDATA_W-1:0]    prdata,
  output logic                             pready
);

  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int FILL_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W  = (FILL_W > falru_pkg::CAP_W) ? FILL_W : falru_pkg::CAP_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LOOK = 2'b10
  } state_t;

  state_t state;

  logic [falru_pkg::CAP_W-1:0] capacity;
  logic [ADDR_BITS-1:0]        tag   [MAX_ENTRIES];
  logic [IDX_W-1:0]            rank  [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]      valid;
  logic [FILL_W-1:0]           fill_level;
  logic [ADDR_BITS-1:0]        addr_q;
  logic [falru_pkg::CNT_W-1:0] accesses;
  logic [falru_pkg::CNT_W-1:0] compulsory_misses;
  logic [falru_pkg::CNT_W-1:0] capacity_misses;
  logic [falru_pkg::CNT_W-1:0] accesses_next;
  logic [falru_pkg::CNT_W-1:0] compulsory_next;
  logic [falru_pkg::CNT_W-1:0] capacity_next;

  logic                        out_valid;
  logic                        out_hit;
  falru_pkg::miss_kind_t       out_kind;
  logic [falru_pkg::CNT_W-1:0] out_acc;
  logic [falru_pkg::CNT_W-1:0] out_comp;
  logic [falru_pkg::CNT_W-1:0] out_cap;

  logic [ADDR_BITS-1:0]   acc_addr;
  falru_pkg::seen_req_t   seen_req;
  logic                   seen_rd;
  logic                   seen_ready;
  logic                   accept;
  logic                   commit;

  logic [MAX_ENTRIES-1:0] hit_vec;
  logic [MAX_ENTRIES-1:0] victim_vec;
  logic [MAX_ENTRIES-1:0] fill_vec;
  logic [MAX_ENTRIES-1:0] slot_vec;
  logic [IDX_W-1:0]       hit_rank;
  logic [IDX_W-1:0]       last_rank;
  logic [CMP_W-1:0]       cap_ext;
  logic [CMP_W-1:0]       eff_cap;
  logic                   is_hit;
  logic                   can_fill;

  generate
    if (ADDR_BITS <= falru_pkg::ADDR_W) begin : g_addr_trunc
      assign acc_addr = access.address[ADDR_BITS-1:0];
    end else begin : g_addr_ext
      assign acc_addr = {{(ADDR_BITS - falru_pkg::ADDR_W){1'b0}}, access.address};
    end
  endgenerate

  assign access.ready = (state == S_IDLE) && seen_ready;
  assign accept       = access.valid && access.ready;
  assign commit       = (state == S_LOOK) && (!out_valid || result.ready);

  assign seen_req.rd_en = accept;
  assign seen_req.wr_en = commit;

  falru_seen_map #(
    .ADDR_BITS (ADDR_BITS)
  ) u_seen (
    .clk     (clk),
    .rst     (rst),
    .req     (seen_req),
    .rd_addr (acc_addr),
    .wr_addr (addr_q),
    .rd_data (seen_rd),
    .ready   (seen_ready)
  );

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr == falru_pkg::CAPACITY_ADDR) ? falru_pkg::PDATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= falru_pkg::CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready && paddr == falru_pkg::CAPACITY_ADDR) begin
      capacity <= pwdata[falru_pkg::CAP_W-1:0];
    end
  end

  // Zero capacity acts as one entry, and anything above the built size is clipped.
  assign cap_ext = CMP_W'(capacity);
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
      eff_cap = CMP_W'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign can_fill  = CMP_W'(fill_level) < eff_cap;
  assign last_rank = IDX_W'(fill_level - 1'b1);

  // Valid ranks always form a permutation of 0 .. fill_level-1, so the least
  // recently used entry is the one whose rank equals fill_level-1.
  always_comb begin
    hit_rank = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_vec[i]    = valid[i] && (tag[i] == addr_q);
      victim_vec[i] = valid[i] && (rank[i] == last_rank);
      fill_vec[i]   = (FILL_W'(i) == fill_level);
      hit_rank      = hit_rank | (hit_vec[i] ? rank[i] : '0);
    end
  end

  assign is_hit   = |hit_vec;
  assign slot_vec = is_hit ? hit_vec : (can_fill ? fill_vec : victim_vec);

  // Saturating counter updates for the item in the lookup stage.
  always_comb begin
    accesses_next   = (accesses == '1) ? accesses : accesses + 1'b1;
    compulsory_next = compulsory_misses;
    capacity_next   = capacity_misses;
    if (!is_hit && !seen_rd && compulsory_misses != '1) begin
      compulsory_next = compulsory_misses + 1'b1;
    end
    if (!is_hit && seen_rd && capacity_misses != '1) begin
      capacity_next = capacity_misses + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      valid             <= '0;
      fill_level        <= '0;
      accesses          <= '0;
      compulsory_misses <= '0;
      capacity_misses   <= '0;
      out_valid         <= 1'b0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      if (commit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (commit) begin
            state             <= S_IDLE;
            out_hit           <= is_hit;
            out_acc           <= accesses_next;
            out_comp          <= compulsory_next;
            out_cap           <= capacity_next;
            accesses          <= accesses_next;
            compulsory_misses <= compulsory_next;
            capacity_misses   <= capacity_next;
            if (is_hit) begin
              out_kind <= falru_pkg::KIND_HIT;
            end else if (seen_rd) begin
              out_kind <= falru_pkg::KIND_CAPACITY;
            end else begin
              out_kind <= falru_pkg::KIND_COMPULSORY;
            end
            if (!is_hit && can_fill) begin
              fill_level <= fill_level + 1'b1;
            end
            // Age the entries more recent than the promoted one (all of them on a miss).
            for (int i = 0; i < MAX_ENTRIES; i++) begin
              if (slot_vec[i]) begin
                rank[i]  <= '0;
                valid[i] <= 1'b1;
              end else if (valid[i] && (!is_hit || rank[i] < hit_rank)) begin
                rank[i] <= rank[i] + 1'b1;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (commit && !is_hit) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (slot_vec[i]) begin
          tag[i] <= addr_q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_q <= acc_addr;
    end
  end

  assign result.valid            = out_valid;
  assign result.hit              = out_hit;
  assign result.miss_kind        = out_kind;
  assign result.access_count     = out_acc;
  assign result.compulsory_count = out_comp;
  assign result.capacity_count   = out_cap;

endmodule

// ----- src/falru_checker.sv -----
`timescale 1ns / 1ps
`include "fully_associative_lru_cache_classifier_macros.svh"

module falru_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         access_valid,
  input logic                         access_ready,
  input logic                         result_valid,
  input logic                         result_ready,
  input logic                         result_hit,
  input logic [falru_pkg::KIND_W-1:0] result_miss_kind,
  input logic [falru_pkg::CNT_W-1:0]  result_access_count
);

  // The miss kind agrees with the hit flag and is a defined kind on every shown result.
  `FALRU_ASSERT_SAME(a_kind_matches_hit, clk, rst, result_valid, (result_hit == (result_miss_kind == falru_pkg::KIND_HIT)) && (result_miss_kind <= falru_pkg::KIND_CAPACITY), "miss kind disagrees with hit flag")

  // The seen-address memory is still being cleared right after reset.
  `FALRU_ASSERT_SAME(a_no_item_after_reset, clk, rst, $fell(rst), !access_ready, "item accepted during the clearing pass")

  // No item is accepted back to back while the lookup is busy.
  `FALRU_ASSERT_NEXT(a_two_cycle_item, clk, rst, access_valid && access_ready, !access_ready, "item accepted back to back")

  // A stalled result holds its count.
  `FALRU_ASSERT_NEXT(a_result_holds, clk, rst, result_valid && !result_ready, result_valid && $stable(result_access_count), "stalled result changed")

endmodule

bind fully_associative_lru_cache_classifier falru_checker u_falru_checker (
  .clk                 (clk),
  .rst                 (rst),
  .access_valid        (access.valid),
  .access_ready        (access.ready),
  .result_valid        (result.valid),
  .result_ready        (result.ready),
  .result_hit          (result.hit),
  .result_miss_kind    (result.miss_kind),
  .result_access_count (result.access_count)
);
